@@ hdl/bsep_pkg.sv @@
// Shared types and constants for the bounded subset equal partition block.
package bsep_pkg;
   localparam int DefReachBits  = 65536;
   localparam int DefCountWidth = 12;
   localparam int WeightClasses = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_NEXT,
      ST_FOLD,
      ST_FOLD_WAIT,
      ST_READ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_start;
      logic piece_start;
      logic fold_start;
      logic read_start;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic trivial_no;
      logic clear_done;
      logic pieces_done;
      logic piece_skip;
      logic fold_done;
      logic read_done;
   } sts_type;
endpackage

@@ hdl/bsep_datapath.sv @@
// Datapath: count registers, piece generator, bitmap memory and fold engine.
module bsep_datapath #(
   parameter int ReachBits  = bsep_pkg::DefReachBits,
   parameter int CountWidth = bsep_pkg::DefCountWidth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CountWidth-1:0]     cnt_in [bsep_pkg::WeightClasses],
   input  bsep_pkg::cmd_type         cmd,
   output bsep_pkg::sts_type         sts,
   output logic                      answer
);
   import bsep_pkg::*;

   localparam int Words   = (ReachBits + 63) / 64;
   localparam int AW      = (Words > 1) ? $clog2(Words) : 1;
   localparam int TW      = CountWidth + 6;
   localparam int SW      = CountWidth + 3;

   logic [63:0] mem [Words];

   logic [CountWidth-1:0] cnt_ff [WeightClasses];
   logic [TW-1:0]         total;
   logic [TW-2:0]         half_ff;
   logic                  odd_ff, big_ff;
   logic [AW-1:0]         top_ff;

   // piece generator
   logic [2:0]            cls_ff;
   logic [CountWidth-1:0] rem_ff;
   logic [CountWidth:0]   piece_ff;
   logic [SW-1:0]         s_ff;
   logic [AW-1:0]         q_ff;
   logic [5:0]            r_ff;

   // sweep engine
   logic                  busy_ff;

   always_comb begin
      total = '0;
      for (int i = 0; i < WeightClasses; i++)
         total = total + TW'(i + 1) * TW'(cnt_in[i]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < WeightClasses; i++) cnt_ff[i] <= cnt_in[i];
         odd_ff  <= total[0];
         half_ff <= total[TW-1:1];
         big_ff  <= (32'(total[TW-1:1]) >= 32'(ReachBits));
         top_ff  <= AW'(total[TW-1:7]);
      end
   end

   assign sts.trivial_no = odd_ff | big_ff;

   // piece sequencing: at most one piece per piece_start; an exhausted class moves on
   logic [CountWidth-1:0] take;
   logic [SW-1:0]         s_calc;
   always_comb begin
      take   = (CountWidth'(piece_ff) < rem_ff && piece_ff[CountWidth] == 1'b0)
               ? CountWidth'(piece_ff) : rem_ff;
      s_calc = SW'(cls_ff + 3'd1) * SW'(take);
   end

   logic piece_valid_ff, pieces_done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pieces_done_ff <= 1'b0;
         piece_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         cls_ff         <= '0;
         rem_ff         <= cnt_in[0];
         piece_ff       <= (CountWidth+1)'(1);
         pieces_done_ff <= 1'b0;
         piece_valid_ff <= 1'b0;
      end else if (cmd.piece_start) begin
         piece_valid_ff <= 1'b0;
         if (rem_ff == '0) begin
            if (cls_ff == 3'(WeightClasses - 1)) pieces_done_ff <= 1'b1;
            else begin
               cls_ff   <= cls_ff + 3'd1;
               rem_ff   <= cnt_ff[cls_ff + 3'd1];
               piece_ff <= (CountWidth+1)'(1);
            end
         end else begin
            rem_ff         <= rem_ff - take;
            piece_ff       <= piece_ff << 1;
            s_ff           <= s_calc;
            piece_valid_ff <= 1'b1;
         end
      end
   end
   logic s_skip;
   assign s_skip = (32'(s_ff) > 32'(half_ff)) || !piece_valid_ff;
   assign sts.pieces_done = pieces_done_ff;
   assign sts.piece_skip  = s_skip;
   always_ff @(posedge clock) begin
      q_ff <= AW'(s_ff >> 6);
      r_ff <= s_ff[5:0];
   end

   // memory sweep: clear (up), fold (down, three reads per word), read answer
   typedef enum logic [1:0] {M_CLEAR, M_FOLD, M_READ} mode_type;
   mode_type mode_ff;
   logic [AW-1:0] addr;
   logic [AW-1:0] src_a;
   logic          rd_en, wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data, rd_data_ff;
   logic          done_ff;
   logic [1:0]    step_ff;
   logic [AW-1:0] cur_ff;
   logic [63:0]   a_ff, b_ff;
   logic [63:0]   shifted;

   always_comb begin
      src_a = cur_ff - q_ff;
      addr  = '0;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = '0;
      if (r_ff == 6'd0 || src_a == '0)
         shifted = a_ff << r_ff;
      else
         shifted = (a_ff << r_ff) | (b_ff >> (7'd64 - {1'b0, r_ff}));
      if (busy_ff) begin
         unique case (mode_ff)
            M_CLEAR: begin
               wr_en   = 1'b1;
               wr_data = (cur_ff == '0) ? 64'd1 : 64'd0;
            end
            M_FOLD: begin
               unique case (step_ff)
                  2'd0: begin addr = src_a; rd_en = 1'b1; end
                  2'd1: begin addr = src_a - AW'(1); rd_en = 1'b1; end
                  2'd2: begin addr = cur_ff; rd_en = 1'b1; end
                  default: begin
                     wr_en   = 1'b1;
                     wr_data = rd_data_ff | shifted;
                  end
               endcase
            end
            default: begin addr = top_ff; rd_en = 1'b1; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.clear_start) begin
            busy_ff <= 1'b1; mode_ff <= M_CLEAR; cur_ff <= '0;
         end else if (cmd.fold_start) begin
            busy_ff <= 1'b1; mode_ff <= M_FOLD; cur_ff <= top_ff; step_ff <= 2'd0;
         end else if (cmd.read_start) begin
            busy_ff <= 1'b1; mode_ff <= M_READ; step_ff <= 2'd0;
         end else if (busy_ff) begin
            unique case (mode_ff)
               M_CLEAR: begin
                  if (cur_ff == top_ff) begin busy_ff <= 1'b0; done_ff <= 1'b1; end
                  else cur_ff <= cur_ff + AW'(1);
               end
               M_FOLD: begin
                  step_ff <= step_ff + 2'd1;
                  if (step_ff == 2'd1) a_ff <= rd_data_ff;
                  if (step_ff == 2'd2) b_ff <= rd_data_ff;
                  if (step_ff == 2'd3) begin
                     if (cur_ff == q_ff) begin busy_ff <= 1'b0; done_ff <= 1'b1; end
                     else cur_ff <= cur_ff - AW'(1);
                  end
               end
               default: begin
                  busy_ff <= 1'b0; done_ff <= 1'b1;
               end
            endcase
         end
      end
   end
   // step 1 captures word src (read in step 0); step 2 captures src-1 (read in step 1)
   assign sts.clear_done = done_ff && mode_ff == M_CLEAR;
   assign sts.fold_done  = done_ff && mode_ff == M_FOLD;
   assign sts.read_done  = done_ff && mode_ff == M_READ;
   assign answer = rd_data_ff[half_ff[5:0]];
endmodule

@@ hdl/bsep_control.sv @@
// Controller state machine sequencing clear, folds and answer read.
module bsep_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bsep_pkg::cmd_type  cmd,
   input  bsep_pkg::sts_type  sts,
   input  logic               answer,
   output logic               rsp_can_divide
);
   import bsep_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in, res_ff, res_in;
   logic      out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_can_divide = out_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      valid_in  = valid_ff && rsp_stall;
      res_in    = res_ff;
      out_in    = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (sts.trivial_no) begin
               res_in = 1'b0; state_in = ST_DONE;
            end else begin
               cmd.clear_start = 1'b1; state_in = ST_FOLD_WAIT;
            end
         end
         ST_FOLD_WAIT: begin
            if (sts.clear_done || sts.fold_done) begin
               cmd.piece_start = 1'b1; state_in = ST_NEXT;
            end
         end
         ST_NEXT: state_in = ST_FOLD;
         ST_FOLD: begin
            if (sts.pieces_done) begin
               cmd.read_start = 1'b1; state_in = ST_READ_WAIT;
            end else if (sts.piece_skip) begin
               cmd.piece_start = 1'b1; state_in = ST_NEXT;
            end else begin
               cmd.fold_start = 1'b1; state_in = ST_FOLD_WAIT;
            end
         end
         ST_READ_WAIT: begin
            if (sts.read_done) begin
               res_in = answer; state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_DONE;
         default: begin
            if (!valid_ff || !rsp_stall) begin
               valid_in = 1'b1; out_in = res_ff; cmd.finish = 1'b1; state_in = ST_IDLE;
            end
         end
      endcase
   end
endmodule

@@ hdl/bounded_subset_equal_partition_top.sv @@
// Equal-weight partition checker: one query in, one yes/no word out.
// Each binary piece of each count folds the bitmap words from half/64 down to
// shift/64, after a clear sweep of half/64+1 words; an odd total or one too
// large for the bitmap skips the sweeps and answers no.
// One query at a time; the single-port bitmap memory sets the rate.
// Synchronous reset clears control; bitmap contents are rebuilt per query.
module bounded_subset_equal_partition_top #(
   parameter int ReachBits  = bsep_pkg::DefReachBits,
   parameter int CountWidth = bsep_pkg::DefCountWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CountWidth-1:0] req_count_weight_one,
   input  logic [CountWidth-1:0] req_count_weight_two,
   input  logic [CountWidth-1:0] req_count_weight_three,
   input  logic [CountWidth-1:0] req_count_weight_four,
   input  logic [CountWidth-1:0] req_count_weight_five,
   input  logic [CountWidth-1:0] req_count_weight_six,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_can_divide
);
   import bsep_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    answer;
   logic [CountWidth-1:0] cnt [WeightClasses];

   assign cnt[0] = req_count_weight_one;
   assign cnt[1] = req_count_weight_two;
   assign cnt[2] = req_count_weight_three;
   assign cnt[3] = req_count_weight_four;
   assign cnt[4] = req_count_weight_five;
   assign cnt[5] = req_count_weight_six;

   bsep_datapath #(.ReachBits(ReachBits), .CountWidth(CountWidth)) u_dp (
      .clock(clock), .reset(reset), .cnt_in(cnt), .cmd(cmd), .sts(sts), .answer(answer)
   );

   bsep_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts),
      .answer(answer), .rsp_can_divide(rsp_can_divide)
   );
endmodule
